>>> rtl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

   typedef logic [1:0] bbc_kind_type;

   localparam bbc_kind_type KIND_ROUND  = 2'd0;
   localparam bbc_kind_type KIND_SQUARE = 2'd1;
   localparam bbc_kind_type KIND_CURLY  = 2'd2;
   localparam bbc_kind_type KIND_NONE   = 2'd3;

   localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

   typedef enum logic [1:0] {
      STATUS_BALANCED = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_UNCLOSED = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } bbc_status_type;

   function automatic bbc_kind_type opener_kind(input logic [7:0] b);
      bbc_kind_type k;
      unique case (b)
         CHAR_ROUND_OPEN:  k = KIND_ROUND;
         CHAR_SQUARE_OPEN: k = KIND_SQUARE;
         CHAR_CURLY_OPEN:  k = KIND_CURLY;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] closer_of(input bbc_kind_type k);
      logic [7:0] c;
      unique case (k)
         KIND_ROUND:  c = CHAR_ROUND_CLOSE;
         KIND_SQUARE: c = CHAR_SQUARE_CLOSE;
         KIND_CURLY:  c = CHAR_CURLY_CLOSE;
         default:     c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bbc_stream_if.sv
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_string;

   modport source (output valid, output char_byte, output end_of_string, input ready);
   modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/bracket_balance_checker_unit.sv
// bracket balance checker
// req_chan (sink): one beat per character; a beat with end_of_string set ends the
//   string and asks for the verdict (its char_byte is ignored)
// rsp_chan (source): one beat per terminator carrying status:
//   0 balanced, 1 mismatch, unexpected closer or other non-opener byte, 2 unclosed openers, 3 overflow
// throughput: one beat per cycle while no terminator waits on a held status, with no
//   bubbles between strings; the open bracket kinds live in a DEPTH x 2 synchronous
//   ram, the top kind in a register and the kind below it in the registered ram read,
//   so a push or pop completes in the cycle of its beat
// latency: the status beat is valid the cycle after the terminator is taken
// after the terminator the block is clear and takes the next string at once
// reset (synchronous, active high) empties the stack and clears the error; the
//   ram is not cleared and needs no pass, so beats are taken right away
// rsp stall: a waiting status stays in the output register; character beats are
//   still taken, and only a further terminator waits until the status is taken
`default_nettype none

module bracket_balance_checker_unit #(
   parameter int DEPTH = 256
) (
   input  wire            clock,
   input  wire            reset,
   bbc_req_if.sink        req_chan,
   bbc_rsp_if.source      rsp_chan
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] COUNT_ONE  = CW'(1);
   localparam logic [CW-1:0] COUNT_TWO  = CW'(2);

   bbc_pkg::bbc_kind_type kind_mem [DEPTH];

   logic [CW-1:0]          count_ff, count_in;
   bbc_pkg::bbc_kind_type  top_ff, top_in;
   bbc_pkg::bbc_kind_type  below_ff;
   bbc_pkg::bbc_status_type err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bbc_pkg::bbc_status_type rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   push;
   logic [CW-1:0]          rd_count;
   bbc_pkg::bbc_kind_type  kind;

   assign req_chan.ready = !req_chan.end_of_string || !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign kind   = bbc_pkg::opener_kind(req_chan.char_byte);

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      err_in   = err_ff;
      push     = 1'b0;
      if (accept) begin
         if (req_chan.end_of_string) begin
            count_in = '0;
            err_in   = bbc_pkg::STATUS_BALANCED;
         end else if (err_ff == bbc_pkg::STATUS_BALANCED) begin
            if (kind != bbc_pkg::KIND_NONE) begin
               if (count_ff == COUNT_FULL) begin
                  err_in = bbc_pkg::STATUS_OVERFLOW;
               end else begin
                  push     = 1'b1;
                  count_in = count_ff + COUNT_ONE;
                  top_in   = kind;
               end
            end else if (count_ff == '0) begin
               err_in = bbc_pkg::STATUS_MISMATCH;
            end else if (req_chan.char_byte != bbc_pkg::closer_of(top_ff)) begin
               err_in = bbc_pkg::STATUS_MISMATCH;
            end else begin
               count_in = count_ff - COUNT_ONE;
               top_in   = below_ff;
            end
         end
      end
   end

   // keep the entry under the new top on the ram output
   assign rd_count = count_in - COUNT_TWO;

   always_ff @(posedge clock) begin
      if (push) begin
         kind_mem[count_ff[AW-1:0]] <= kind;
      end
      below_ff <= kind_mem[rd_count[AW-1:0]];
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      if (accept && req_chan.end_of_string) begin
         rsp_valid_in = 1'b1;
         if (err_ff != bbc_pkg::STATUS_BALANCED) begin
            rsp_status_in = err_ff;
         end else if (count_ff != '0) begin
            rsp_status_in = bbc_pkg::STATUS_UNCLOSED;
         end else begin
            rsp_status_in = bbc_pkg::STATUS_BALANCED;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= bbc_pkg::STATUS_BALANCED;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("stack count above depth");

   a_error_freezes_stack: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.end_of_string && err_ff != bbc_pkg::STATUS_BALANCED
      |=> $stable(count_ff) && $stable(err_ff))
      else $error("stack changed after error");

   a_terminator_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_of_string
      |=> count_ff == '0 && err_ff == bbc_pkg::STATUS_BALANCED && rsp_valid_ff)
      else $error("terminator did not clear state or post status");

   a_status_from_terminator: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_chan.end_of_string))
      else $error("status beat without terminator");

   a_held_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_status_ff))
      else $error("stalled status lost");
`endif

endmodule

`default_nettype wire

>>> tb/bbc_checker.sv
`default_nettype none

module bbc_checker #(
   parameter int DEPTH = 256
) (
   input  wire        clock,
   input  wire        reset,
   bbc_req_if         req,
   bbc_rsp_if         rsp,
   output int         mismatch_count,
   output int         expected_left
);

   bbc_pkg::bbc_kind_type   kinds_held [DEPTH];
   int                      held;
   bbc_pkg::bbc_status_type first_err;
   bbc_pkg::bbc_status_type status_q [$];

   always @(posedge clock) begin
      bbc_pkg::bbc_kind_type   kind;
      bbc_pkg::bbc_status_type want;
      logic [7:0]              want_close;
      if (reset) begin
         held = 0;
         first_err = bbc_pkg::STATUS_BALANCED;
         status_q.delete();
      end else begin
         // the status beat answers an older terminator, so check it first
         if (rsp.valid && rsp.ready) begin
            if (status_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: status beat %0d with no terminator waiting", $time, rsp.status);
            end else begin
               want = status_q.pop_front();
               if (rsp.status !== want) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d (%s) actual %0d",
                           $time, want, want.name(), rsp.status);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.end_of_string) begin
               if (first_err != bbc_pkg::STATUS_BALANCED) status_q.push_back(first_err);
               else if (held != 0) status_q.push_back(bbc_pkg::STATUS_UNCLOSED);
               else status_q.push_back(bbc_pkg::STATUS_BALANCED);
               held = 0;
               first_err = bbc_pkg::STATUS_BALANCED;
            end else if (first_err == bbc_pkg::STATUS_BALANCED) begin
               case (req.char_byte)
                  bbc_pkg::CHAR_ROUND_OPEN:  kind = bbc_pkg::KIND_ROUND;
                  bbc_pkg::CHAR_SQUARE_OPEN: kind = bbc_pkg::KIND_SQUARE;
                  bbc_pkg::CHAR_CURLY_OPEN:  kind = bbc_pkg::KIND_CURLY;
                  default:                   kind = bbc_pkg::KIND_NONE;
               endcase
               if (kind != bbc_pkg::KIND_NONE) begin
                  if (held >= DEPTH) begin
                     first_err = bbc_pkg::STATUS_OVERFLOW;
                  end else begin
                     kinds_held[held] = kind;
                     held++;
                  end
               end else if (held == 0) begin
                  first_err = bbc_pkg::STATUS_MISMATCH;
               end else begin
                  case (kinds_held[held - 1])
                     bbc_pkg::KIND_ROUND:  want_close = bbc_pkg::CHAR_ROUND_CLOSE;
                     bbc_pkg::KIND_SQUARE: want_close = bbc_pkg::CHAR_SQUARE_CLOSE;
                     default:              want_close = bbc_pkg::CHAR_CURLY_CLOSE;
                  endcase
                  if (req.char_byte != want_close) first_err = bbc_pkg::STATUS_MISMATCH;
                  else held--;
               end
            end
         end
      end
      expected_left = status_q.size();
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;

   localparam int DEPTH        = 256;
   localparam int RANDOM_BEATS = 270;
   localparam int UNWIND_FILL  = 48;
   localparam int STALL_LIMIT  = 3000;

   logic clock;
   logic reset;

   bbc_req_if req_chan ();
   bbc_rsp_if rsp_chan ();

   int send_idle_pct;
   int rsp_stall_pct;
   int beats_sent;
   int strings_sent;
   int stall_cycles;
   int mismatch_count;
   int expected_left;
   int status_seen [4];
   logic [7:0] str_buf [$];

   bracket_balance_checker_unit #(.DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bbc_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) status_seen[rsp_chan.status]++;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] bracket_char(input bbc_pkg::bbc_kind_type k,
                                               input logic closing);
      case (k)
         bbc_pkg::KIND_ROUND:
            return closing ? bbc_pkg::CHAR_ROUND_CLOSE : bbc_pkg::CHAR_ROUND_OPEN;
         bbc_pkg::KIND_SQUARE:
            return closing ? bbc_pkg::CHAR_SQUARE_CLOSE : bbc_pkg::CHAR_SQUARE_OPEN;
         default:
            return closing ? bbc_pkg::CHAR_CURLY_CLOSE : bbc_pkg::CHAR_CURLY_OPEN;
      endcase
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.char_byte     <= b;
      req_chan.end_of_string <= eos;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_str_buf();
      foreach (str_buf[i]) send_beat(str_buf[i], 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1);
      strings_sent++;
   endtask

   task automatic send_text(input string s);
      str_buf.delete();
      for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
      send_str_buf();
   endtask

   // push fill openers, then either unwind them or push one more and three random bytes
   task automatic send_deep(input int fill, input logic overflow);
      bbc_pkg::bbc_kind_type kinds [$];
      bbc_pkg::bbc_kind_type k;
      str_buf.delete();
      repeat (fill) begin
         k = bbc_pkg::bbc_kind_type'($urandom_range(2));
         kinds.push_back(k);
         str_buf.push_back(bracket_char(k, 1'b0));
      end
      if (overflow) begin
         str_buf.push_back(bracket_char(bbc_pkg::bbc_kind_type'($urandom_range(2)), 1'b0));
         repeat (3) str_buf.push_back(8'($urandom_range(255)));
      end else begin
         while (kinds.size() > 0) str_buf.push_back(bracket_char(kinds.pop_back(), 1'b1));
      end
      send_str_buf();
   endtask

   task automatic send_random_string();
      bbc_pkg::bbc_kind_type kinds [$];
      bbc_pkg::bbc_kind_type k;
      int mode;
      int n;
      mode = $urandom_range(99);
      str_buf.delete();
      if (mode < 85) begin
         n = $urandom_range(1, 16);
         repeat (n) begin
            if (kinds.size() == 0 || ($urandom_range(1) == 1 && kinds.size() < 12)) begin
               k = bbc_pkg::bbc_kind_type'($urandom_range(2));
               kinds.push_back(k);
               str_buf.push_back(bracket_char(k, 1'b0));
            end else begin
               str_buf.push_back(bracket_char(kinds.pop_back(), 1'b1));
            end
         end
         if ($urandom_range(9) != 0)
            while (kinds.size() > 0) str_buf.push_back(bracket_char(kinds.pop_back(), 1'b1));
         // broken sequence: one character replaced by any byte
         if (mode >= 70) str_buf[$urandom_range(str_buf.size() - 1)] = 8'($urandom_range(255));
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(1) == 1)
               str_buf.push_back(bracket_char(bbc_pkg::bbc_kind_type'($urandom_range(2)),
                                              1'($urandom_range(1))));
            else
               str_buf.push_back(8'($urandom_range(255)));
         end
      end
      send_str_buf();
   endtask

   initial begin
      int random_base;
      req_chan.valid         <= 1'b0;
      req_chan.char_byte     <= 8'h00;
      req_chan.end_of_string <= 1'b0;
      reset                  <= 1'b1;
      send_idle_pct = 14;
      rsp_stall_pct = 53;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_text("()");
      send_text("[{}]");
      send_text(")");
      send_text("(]");
      send_text("{a}");
      send_text("((");
      send_beat(8'h00, 1'b1);
      strings_sent++;
      str_buf = '{8'hFF};
      send_str_buf();
      send_deep(UNWIND_FILL, 1'b0);
      send_deep(DEPTH, 1'b1);

      random_base = beats_sent;
      while (beats_sent - random_base < RANDOM_BEATS) begin
         if (beats_sent - random_base >= 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end else if (beats_sent - random_base >= RANDOM_BEATS / 3) begin
            send_idle_pct = 53;
            rsp_stall_pct = 14;
         end
         send_random_string();
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      wait (expected_left == 0);
      repeat (10) @(posedge clock);
      $display("%0d strings in %0d beats, one nested %0d deep and one overflowing at %0d",
               strings_sent, beats_sent, UNWIND_FILL, DEPTH);
      $display("status beats: balanced %0d, mismatch %0d, unclosed %0d, overflow %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/bbc_pkg.sv
rtl/bbc_stream_if.sv
rtl/bracket_balance_checker_unit.sv
tb/bbc_checker.sv
tb/tb_top.sv
